@@ rtl/dldf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dldf_pkg
// Shared constants and types of the delimiter-run deframer.
// ----------------------------------------------------------------------------
package dldf_pkg;

  // Run length bounds; descriptor fields are sized for the largest run.
  localparam int unsigned DelimLenDef = 4;
  localparam int unsigned DelimLenMax = 8;

  // Delimiter bytes released in one step stay below the run length.
  localparam int unsigned NdW  = $clog2(DelimLenMax);
  // Results per step reach run length plus one.
  localparam int unsigned CntW = $clog2(DelimLenMax + 2);

  localparam logic [7:0] DelimReset = 8'hFE;
  localparam logic       SkipReset  = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] RegDelimiter  = 8'd0;
  localparam logic [7:0] RegSkipHeader = 8'd1;

  // Result list of one input byte: [held] [delim x nd] [data], count beats.
  typedef struct packed {
    logic [7:0]      held_byte;
    logic            held_valid;
    logic [7:0]      delim_byte;
    logic [7:0]      data_byte;
    logic [NdW-1:0]  num_delim;
    logic [CntW-1:0] count;
    logic            close;
  } burst_desc_t;

  typedef struct packed {
    logic busy;
    logic on_last;
  } burst_stat_t;

endpackage
`default_nettype wire

@@ rtl/delimiter_run_deframer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_run_deframer
// Splits a byte stream into packets at runs of a delimiter byte.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_ready_o  data_byte_i, end_of_buffer_i
//  out      out  out_valid_o/out_ready_i packet_byte_o, packet_last_o
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  An input beat is decoded in the cycle it is accepted; its results (0 to
//  DelimLen+1 beats) leave from the result register one per cycle after it
//  while out_ready_i is high. A byte with at most one result sustains one beat
//  per cycle; a byte that gives more results holds the input while the result
//  register drains. Reset clears the framing state; the next byte is a header
//  byte. Output stalls back up to in_ready_o; the config port is always ready.
// ----------------------------------------------------------------------------
module delimiter_run_deframer import dldf_pkg::*; #(
  parameter int unsigned DelimLen = DelimLenDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_buffer_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      packet_byte_o,
  output logic            packet_last_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0]  delim_q;
  logic        skip_q;
  logic        in_fire, take, load;
  burst_desc_t desc;
  burst_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
      skip_q  <= SkipReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDelimiter:  delim_q <= cfg_data_i;
        RegSkipHeader: skip_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = stat.busy;
  assign take        = out_valid_o && out_ready_i;
  // free when empty or when the final beat leaves this cycle
  assign in_ready_o  = !stat.busy || (out_ready_i && stat.on_last);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load        = in_fire && (desc.count != '0);

  dldf_frame #(
    .DelimLen(DelimLen)
  ) u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .data_byte_i    (data_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .delim_i        (delim_q),
    .skip_i         (skip_q),
    .desc_o         (desc)
  );

  dldf_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .desc_i       (desc),
    .take_i       (take),
    .stat_o       (stat),
    .packet_byte_o(packet_byte_o),
    .packet_last_o(packet_last_o)
  );

  a_accept_only_when_draining: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire && out_valid_o |-> out_ready_i && stat.on_last
  ) else $error("input accepted while results still pending");

  a_burst_continues: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    take && !stat.on_last |=> out_valid_o
  ) else $error("result burst ended early");

  a_load_shows_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o
  ) else $error("loaded results not presented");

  a_last_on_final_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_last_o |-> stat.on_last
  ) else $error("packet end flagged before final beat of burst");

endmodule
`default_nettype wire

@@ rtl/dldf_frame.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dldf_frame
// Framing state and per-byte decode into a result list descriptor.
// ----------------------------------------------------------------------------
module dldf_frame import dldf_pkg::*; #(
  parameter int unsigned DelimLen = DelimLenDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_buffer_i,
  input  wire logic [7:0]  delim_i,
  input  wire logic        skip_i,
  output burst_desc_t      desc_o
);

  localparam int unsigned RunW = $clog2(DelimLen);

  logic [RunW-1:0] run_q, run_d;
  logic            hv_q, hv_d;
  logic [7:0]      hb_q, hb_d;
  logic            at_q, at_d;

  logic            drop, is_delim, full, plain, hold, close;
  logic [NdW-1:0]  num_delim;
  logic [CntW-1:0] total;

  always_comb begin
    drop     = at_q & skip_i;
    is_delim = !drop && (data_byte_i == delim_i);
    full     = is_delim && (run_q == RunW'(DelimLen - 1));
    plain    = !drop && !is_delim;
    close    = full || end_of_buffer_i;
    hold     = plain && !end_of_buffer_i;

    if (drop) begin
      num_delim = end_of_buffer_i ? NdW'(run_q) : '0;
    end else if (full) begin
      num_delim = '0;
    end else if (is_delim) begin
      num_delim = end_of_buffer_i ? (NdW'(run_q) + NdW'(1)) : '0;
    end else begin
      num_delim = NdW'(run_q);
    end

    total = CntW'(hv_q) + CntW'(num_delim) + CntW'(plain);

    desc_o.held_byte  = hb_q;
    desc_o.held_valid = hv_q;
    desc_o.delim_byte = delim_i;
    desc_o.data_byte  = data_byte_i;
    desc_o.num_delim  = num_delim;
    desc_o.close      = close;
    if (close) begin
      desc_o.count = total;
    end else if (hold) begin
      // keep the newest data byte back for its last flag
      desc_o.count = total - CntW'(1);
    end else begin
      desc_o.count = '0;
    end
  end

  always_comb begin
    at_d = end_of_buffer_i;
    hb_d = plain ? data_byte_i : hb_q;
    if (end_of_buffer_i || full) begin
      hv_d = 1'b0;
    end else if (plain) begin
      hv_d = 1'b1;
    end else begin
      hv_d = hv_q;
    end
    if (end_of_buffer_i) begin
      run_d = '0;
    end else if (is_delim && !full) begin
      run_d = run_q + RunW'(1);
    end else if (drop) begin
      run_d = run_q;
    end else begin
      run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      hv_q  <= 1'b0;
      at_q  <= 1'b1;
    end else if (fire_i) begin
      run_q <= run_d;
      hv_q  <= hv_d;
      at_q  <= at_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hb_q <= hb_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dldf_burst.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dldf_burst
// Result register: one descriptor, played out one beat a cycle while taken.
// ----------------------------------------------------------------------------
module dldf_burst import dldf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  burst_desc_t      desc_i,
  input  wire logic        take_i,
  output burst_stat_t      stat_o,
  output logic [7:0]       packet_byte_o,
  output logic             packet_last_o
);

  burst_desc_t     desc_q;
  logic            busy_q, busy_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            on_last;

  assign on_last = (idx_q == (desc_q.count - CntW'(1)));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (take_i) begin
      busy_d = !on_last;
      idx_d  = idx_q + CntW'(1);
    end
  end

  always_comb begin
    if (desc_q.held_valid && (idx_q == '0)) begin
      packet_byte_o = desc_q.held_byte;
    end else if (idx_q < (CntW'(desc_q.held_valid) + CntW'(desc_q.num_delim))) begin
      packet_byte_o = desc_q.delim_byte;
    end else begin
      packet_byte_o = desc_q.data_byte;
    end
    packet_last_o = desc_q.close && on_last;
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.on_last = on_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_delimiter_run_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimiter_run_deframer
// Drives byte buffers into the deframer under random source and sink stalls,
// predicts every packet beat from an in-bench copy of the framing state, and
// checks each output beat in order. Register settings and stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_delimiter_run_deframer;
  import dldf_pkg::*;

  localparam int unsigned RunLen      = DelimLenDef;
  localparam int unsigned DrainCycles = 2 * (RunLen + 2);
  localparam int unsigned PhaseItems  = 68;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } raw_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_beat_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_eob    = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] packet_byte;
  logic       packet_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data  = 8'h00;

  logic       in_beat_q  = 1'b0;
  logic       cfg_beat_q = 1'b0;
  logic       steady     = 1'b0;
  int unsigned mismatches = 0;

  raw_byte_t raw_q[$];
  pkt_beat_t pkt_q[$];
  raw_byte_t drv_item;
  pkt_beat_t want_beat;

  // Framing state and register copies of the predictor
  logic [7:0]  delim_cfg = DelimReset;
  logic        skip_cfg  = SkipReset;
  int unsigned run_len   = 0;
  logic        held_vld  = 1'b0;
  logic [7:0]  held_data = 8'h00;
  logic        buf_start = 1'b1;

  delimiter_run_deframer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (in_byte),
    .end_of_buffer_i (in_eob),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .packet_byte_o   (packet_byte),
    .packet_last_o   (packet_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pass a data byte through the one-byte hold stage.
  task automatic hold_data(input logic [7:0] b);
    if (held_vld) pkt_q.push_back({held_data, 1'b0});
    held_data = b;
    held_vld  = 1'b1;
  endtask

  // Release held delimiter bytes as data.
  task automatic flush_run();
    while (run_len > 0) begin
      hold_data(delim_cfg);
      run_len--;
    end
  endtask

  task automatic end_packet();
    if (held_vld) pkt_q.push_back({held_data, 1'b1});
    held_vld = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    logic drop;
    drop = 1'b0;
    if (buf_start) begin
      buf_start = 1'b0;
      drop      = skip_cfg;
    end
    if (!drop) begin
      if (b == delim_cfg) begin
        run_len++;
        if (run_len >= RunLen) begin
          run_len = 0;
          end_packet();
        end
      end else begin
        flush_run();
        hold_data(b);
      end
    end
    if (eob) begin
      flush_run();
      end_packet();
      buf_start = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Monitor: predict on input beats, track register writes, check output beats.
  always @(posedge clk) begin
    in_beat_q  <= in_valid && in_ready;
    cfg_beat_q <= cfg_valid && cfg_ready;
    if (in_valid && in_ready) deframe_byte(in_byte, in_eob);
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegDelimiter) delim_cfg = cfg_data;
      else if (cfg_index == RegSkipHeader) skip_cfg = cfg_data[0];
    end
    if (out_valid && out_ready) begin
      if (pkt_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte %02h last %0b",
                                  packet_byte, packet_last));
      end else begin
        want_beat = pkt_q.pop_front();
        if (packet_byte !== want_beat.data)
          report_mismatch($sformatf("packet_byte %02h, want %02h",
                                    packet_byte, want_beat.data));
        if (packet_last !== want_beat.last)
          report_mismatch($sformatf("packet_last %0b, want %0b on byte %02h",
                                    packet_last, want_beat.last, want_beat.data));
      end
    end
  end

  // Driver: load the next byte once the current beat is taken; stall the sink.
  always @(negedge clk) begin
    if (!in_valid || in_beat_q) begin
      if (raw_q.size() > 0 && (steady || $urandom_range(99) >= 29)) begin
        drv_item = raw_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= drv_item.data;
        in_eob   <= drv_item.eob;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 29);
  end

  task automatic add_byte(input logic [7:0] b, input logic eob);
    raw_q.push_back({b, eob});
  endtask

  // Mostly whole buffers with delimiter runs of mixed length, some loose noise.
  task automatic gen_phase(input int unsigned n, input logic [7:0] dl);
    int unsigned added;
    int unsigned len;
    int unsigned k;
    int unsigned run;
    int unsigned j;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(24, 1);
        k   = 0;
        while (k < len && added < n) begin
          if (k > 0 && $urandom_range(99) < 35) begin
            run = ($urandom_range(99) < 50) ? RunLen : $urandom_range(2 * RunLen + 1, 1);
            for (j = 0; j < run && k < len && added < n; j++) begin
              add_byte(dl, k == len - 1);
              k++;
              added++;
            end
          end else begin
            add_byte(8'($urandom_range(255)), k == len - 1);
            k++;
            added++;
          end
        end
      end else begin
        add_byte(($urandom_range(1) == 1) ? dl : 8'($urandom_range(255)),
                 $urandom_range(9) == 0);
        added++;
      end
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_beat_q);
    cfg_valid <= 1'b0;
  endtask

  // Hold until all bytes are taken and all beats are out, then let the block settle.
  // Sample at the rising edge, where the driver's queue and valid are settled.
  task automatic wait_idle();
    while (raw_q.size() != 0 || in_valid || pkt_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    logic [7:0] dl;
    int unsigned k;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Header byte that also ends its buffer
    add_byte(8'h00, 1'b1);
    // Extreme data, full run, partial run released as data, run ending the buffer
    add_byte(8'h77, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    for (k = 0; k < RunLen; k++) add_byte(DelimReset, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(DelimReset, 1'b0);
    add_byte(DelimReset, 1'b0);
    add_byte(8'h34, 1'b0);
    for (k = 0; k < RunLen; k++) add_byte(DelimReset, k == RunLen - 1);
    // Leading run emits no packet; trailing partial run closes as data
    add_byte(8'hA5, 1'b0);
    for (k = 0; k < RunLen; k++) add_byte(DelimReset, 1'b0);
    add_byte(8'h55, 1'b0);
    for (k = 0; k < RunLen - 1; k++) add_byte(DelimReset, k == RunLen - 2);
    wait_idle();

    gen_phase(PhaseItems, DelimReset);
    wait_idle();

    steady = 1'b1;
    write_reg(RegDelimiter, 8'h00);
    write_reg(RegSkipHeader, 8'h00);
    gen_phase(PhaseItems, 8'h00);
    wait_idle();
    steady = 1'b0;

    // Upper bits of the skip flag are masked off
    write_reg(RegDelimiter, 8'hFF);
    write_reg(RegSkipHeader, 8'h03);
    gen_phase(PhaseItems, 8'hFF);
    wait_idle();

    dl = 8'($urandom_range(255));
    write_reg(RegDelimiter, dl);
    write_reg(RegSkipHeader, 8'hFE);
    write_reg(8'($urandom_range(255, RegSkipHeader + 1)), 8'($urandom_range(255)));
    gen_phase(PhaseItems, dl);
    wait_idle();

    write_reg(RegDelimiter, DelimReset);
    write_reg(RegSkipHeader, 8'h01);
    write_reg(8'($urandom_range(255, RegSkipHeader + 1)), 8'($urandom_range(255)));
    gen_phase(PhaseItems, DelimReset);
    wait_idle();

    dl = 8'($urandom_range(255));
    write_reg(RegDelimiter, dl);
    write_reg(RegSkipHeader, 8'($urandom_range(255)));
    gen_phase(PhaseItems, dl);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ delimiter_run_deframer.f @@
rtl/dldf_pkg.sv
rtl/dldf_frame.sv
rtl/dldf_burst.sv
rtl/delimiter_run_deframer.sv
dv/tb_delimiter_run_deframer.sv
